// File: rtl/yay0lz_pkg.sv
// ----------------------------------------------------------------------------
// yay0lz_pkg
// Shared widths, constants and types of the Yay0 LZ decoder back end.
// ----------------------------------------------------------------------------
package yay0lz_pkg;

    // field widths
    localparam int REQ_W   = 1;
    localparam int LIT_W   = 8;
    localparam int LINK_W  = 16;
    localparam int EXTRA_W = 8;
    localparam int DATA_W  = 64;
    localparam int COUNT_W = 4;
    localparam int SIZE_W  = 24;
    localparam int BYTE_W  = 8;

    // link word layout and length bases
    localparam int LEN_SHIFT  = 12;
    localparam int CODE_W     = LINK_W - LEN_SHIFT;
    localparam int LONG_BASE  = 18;
    localparam int SHORT_BASE = 2;

    // distance 1..4096, length 1..273
    localparam int DIST_W = LEN_SHIFT + 1;
    localparam int LEN_W  = 9;

    // result word holds this many bytes
    localparam int OUT_BYTES = DATA_W / BYTE_W;

    localparam int QUEUE_DEPTH = 4;

    localparam int WINDOW_DEPTH_DEF = 4096;
    localparam int LANES_DEF        = 8;

    localparam logic [REQ_W-1:0] REQ_COPY = 1'b1;

    localparam logic [0:0] REG_TOTAL_SIZE = 1'b0;

    typedef struct packed {
        logic              is_copy;
        logic [LIT_W-1:0]  lit;
        logic [DIST_W-1:0] distance;
        logic [LEN_W-1:0]  len;
        logic              bad;
        logic              done;
    } t_token;

    typedef struct packed {
        logic              we;
        logic [SIZE_W-1:0] total_size;
    } t_cfg_wr;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// File: rtl/yay0lz_if.sv
// ----------------------------------------------------------------------------
// yay0lz_if
// Token and result channels of the Yay0 LZ decoder, valid/ready handshake.
// ----------------------------------------------------------------------------
interface yay0lz_tok_if;
    logic                            valid;
    logic                            ready;
    logic [yay0lz_pkg::REQ_W-1:0]    req_type;
    logic [yay0lz_pkg::LIT_W-1:0]    literal_byte;
    logic [yay0lz_pkg::LINK_W-1:0]   link_word;
    logic [yay0lz_pkg::EXTRA_W-1:0]  extra_length;

    modport source (
        output valid, req_type, literal_byte, link_word, extra_length,
        input  ready
    );
    modport sink (
        input  valid, req_type, literal_byte, link_word, extra_length,
        output ready
    );
endinterface

interface yay0lz_res_if;
    logic                            valid;
    logic                            ready;
    logic [yay0lz_pkg::DATA_W-1:0]   data_bytes;
    logic [yay0lz_pkg::COUNT_W-1:0]  byte_count;
    logic                            last;
    logic                            stream_done;
    logic                            bad_ref;

    modport source (
        output valid, data_bytes, byte_count, last, stream_done, bad_ref,
        input  ready
    );
    modport sink (
        input  valid, data_bytes, byte_count, last, stream_done, bad_ref,
        output ready
    );
endinterface

// File: rtl/yay0lz_front.sv
// ----------------------------------------------------------------------------
// yay0lz_front
// Accepts tokens, decodes length and distance, clips to the decoded size
// and flags references before the start of output.
// ----------------------------------------------------------------------------
module yay0lz_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    yay0lz_tok_if.sink              i_tok,
    input  yay0lz_pkg::t_cfg_wr     i_cfg,
    input  yay0lz_pkg::t_q_status   i_q_status,
    output logic                    o_push,
    output yay0lz_pkg::t_token      o_push_data
);

    localparam int SIZE_W = yay0lz_pkg::SIZE_W;
    localparam int LEN_W  = yay0lz_pkg::LEN_W;
    localparam int DIST_W = yay0lz_pkg::DIST_W;

    // bytes produced so far and bytes still missing to the decoded size
    logic [SIZE_W-1:0] r_out_count, n_out_count;
    logic [SIZE_W-1:0] r_remaining, n_remaining;

    logic                          accept;
    logic                          is_copy;
    logic [yay0lz_pkg::CODE_W-1:0] code;
    logic [LEN_W-1:0]              len_raw;
    logic [LEN_W-1:0]              len_clip;
    logic [DIST_W-1:0]             distance;
    logic                          reach_end;

    assign i_tok.ready = !i_q_status.full;
    assign accept      = i_tok.valid && i_tok.ready;

    assign is_copy  = (i_tok.req_type == yay0lz_pkg::REQ_COPY);
    assign code     = i_tok.link_word[yay0lz_pkg::LINK_W-1:yay0lz_pkg::LEN_SHIFT];
    assign distance = DIST_W'(i_tok.link_word[yay0lz_pkg::LEN_SHIFT-1:0]) + DIST_W'(1);

    always_comb begin
        if (!is_copy) begin
            len_raw = LEN_W'(1);
        end else if (code == '0) begin
            len_raw = LEN_W'(i_tok.extra_length) + LEN_W'(yay0lz_pkg::LONG_BASE);
        end else begin
            len_raw = LEN_W'(code) + LEN_W'(yay0lz_pkg::SHORT_BASE);
        end
    end

    assign reach_end = (SIZE_W'(len_raw) >= r_remaining);
    // when clipped the remainder is at most the raw length, so it fits
    assign len_clip  = reach_end ? r_remaining[LEN_W-1:0] : len_raw;

    // a finished stream swallows tokens
    assign o_push = accept && (r_remaining != '0);

    always_comb begin
        o_push_data.is_copy  = is_copy;
        o_push_data.lit      = i_tok.literal_byte;
        o_push_data.distance = distance;
        o_push_data.len      = len_clip;
        o_push_data.bad      = is_copy && (SIZE_W'(distance) > r_out_count);
        o_push_data.done     = reach_end;
    end

    always_comb begin
        n_out_count = r_out_count;
        n_remaining = r_remaining;
        if (i_cfg.we) begin
            n_remaining = (i_cfg.total_size > r_out_count) ?
                          (i_cfg.total_size - r_out_count) : '0;
        end else if (o_push) begin
            n_out_count = r_out_count + SIZE_W'(len_clip);
            n_remaining = r_remaining - SIZE_W'(len_clip);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_count <= '0;
            r_remaining <= '0;
        end else begin
            r_out_count <= n_out_count;
            r_remaining <= n_remaining;
        end
    end

endmodule

// File: rtl/yay0lz_queue.sv
// ----------------------------------------------------------------------------
// yay0lz_queue
// Short token queue between the front end and the copy engine.
// ----------------------------------------------------------------------------
module yay0lz_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  yay0lz_pkg::t_token      i_push_data,
    input  logic                    i_pop,
    output yay0lz_pkg::t_token      o_pop_data,
    output yay0lz_pkg::t_q_status   o_status
);

    localparam int DEPTH = yay0lz_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);

    yay0lz_pkg::t_token r_data [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [PTR_W:0]     r_count;

    logic do_push;
    logic do_pop;

    assign o_status.full  = (r_count == (PTR_W+1)'(DEPTH));
    assign o_status.empty = (r_count == '0);

    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;

    assign o_pop_data = r_data[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (PTR_W+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (PTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_data[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// File: rtl/yay0lz_back.sv
// ----------------------------------------------------------------------------
// yay0lz_back
// Copy engine: banked history ring, groups of up to LANES bytes per
// result, overlapping copies resolved across lanes.
// ----------------------------------------------------------------------------
module yay0lz_back #(
    parameter int WINDOW_DEPTH = yay0lz_pkg::WINDOW_DEPTH_DEF,
    parameter int LANES        = yay0lz_pkg::LANES_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  yay0lz_pkg::t_token      i_pop_data,
    input  yay0lz_pkg::t_q_status   i_q_status,
    output logic                    o_pop,
    yay0lz_res_if.source            o_res
);

    localparam int BYTE_W  = yay0lz_pkg::BYTE_W;
    localparam int LEN_W   = yay0lz_pkg::LEN_W;
    localparam int DIST_W  = yay0lz_pkg::DIST_W;
    localparam int DATA_W  = yay0lz_pkg::DATA_W;
    // ring is rounded up to a power of two, so positions wrap by themselves
    localparam int ADDR_W  = $clog2(WINDOW_DEPTH);
    localparam int BANK_W  = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int BANKS   = 2 ** BANK_W;
    localparam int ROW_W   = ADDR_W - BANK_W;
    localparam int ROWS    = 2 ** ROW_W;
    localparam int CNT_W   = $clog2(LANES + 1);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_READ,
        ST_EMIT
    } t_state;

    t_state                 r_state;
    logic [ADDR_W-1:0]      r_wp;
    yay0lz_pkg::t_token     r_tok;
    logic [LEN_W-1:0]       r_len_left;
    logic                   r_out_valid;
    logic [DATA_W-1:0]      r_out_data;
    logic [yay0lz_pkg::COUNT_W-1:0] r_out_count;
    logic                   r_out_last;
    logic                   r_out_done;
    logic                   r_out_bad;

    logic                   fire;
    logic                   last_group;
    logic [CNT_W-1:0]       chunk;
    logic [ADDR_W:0]        base_ext;
    logic [ADDR_W-1:0]      base;
    logic                   rd_en;
    logic [BYTE_W-1:0]      w_rd      [BANKS];
    logic [BYTE_W-1:0]      rd_lane   [BANKS];
    logic [BYTE_W-1:0]      lane_byte [BANKS];
    logic [DATA_W-1:0]      out_bytes;
    logic                   load_read;

    assign fire       = (r_state == ST_EMIT) && (!r_out_valid || o_res.ready);
    assign last_group = (r_len_left <= LEN_W'(LANES));
    assign chunk      = (r_len_left >= LEN_W'(LANES)) ? CNT_W'(LANES)
                                                      : r_len_left[CNT_W-1:0];
    assign o_pop      = !i_q_status.empty &&
                        ((r_state == ST_LOAD) || (fire && last_group));
    assign load_read  = i_pop_data.is_copy && !i_pop_data.bad;

    // source of lane 0 is one distance behind the write position
    assign base_ext = {1'b0, r_wp} - (ADDR_W+1)'(r_tok.distance);
    assign base     = base_ext[ADDR_W-1:0];
    assign rd_en    = (r_state == ST_READ);

    for (genvar b = 0; b < BANKS; b++) begin : g_bank
        logic [BYTE_W-1:0] r_mem [ROWS];
        logic [BYTE_W-1:0] r_rd;
        logic [BANK_W-1:0] rd_li;
        logic [ADDR_W-1:0] rd_pos;
        logic [ROW_W-1:0]  rd_row;
        logic [BANK_W-1:0] wr_li;
        logic [ADDR_W-1:0] wr_pos;
        logic [ROW_W-1:0]  wr_row;
        logic              wr_en;

        assign rd_li  = BANK_W'(BANK_W'(b) - base[BANK_W-1:0]);
        assign rd_pos = base + ADDR_W'(rd_li);
        assign rd_row = rd_pos[ADDR_W-1:BANK_W];

        assign wr_li  = BANK_W'(BANK_W'(b) - r_wp[BANK_W-1:0]);
        assign wr_pos = r_wp + ADDR_W'(wr_li);
        assign wr_row = wr_pos[ADDR_W-1:BANK_W];
        assign wr_en  = fire && ((BANK_W+1)'(wr_li) < (BANK_W+1)'(chunk));

        always_ff @(posedge i_clk) begin
            if (wr_en) begin
                r_mem[wr_row] <= lane_byte[wr_li];
            end
            if (rd_en) begin
                r_rd <= r_mem[rd_row];
            end
        end

        assign w_rd[b] = r_rd;
    end

    // rotate bank outputs into lane order
    for (genvar i = 0; i < BANKS; i++) begin : g_rot
        assign rd_lane[i] = w_rd[BANK_W'(base[BANK_W-1:0] + BANK_W'(i))];
    end

    // lanes at or past the distance repeat bytes of this same group
    always_comb begin
        for (int i = 0; i < BANKS; i++) begin
            lane_byte[i] = '0;
            if (i < LANES) begin
                if (!r_tok.is_copy) begin
                    lane_byte[i] = r_tok.lit;
                end else if (!r_tok.bad) begin
                    lane_byte[i] = rd_lane[i];
                    for (int d = 1; d <= i; d++) begin
                        if (r_tok.distance == DIST_W'(d)) begin
                            lane_byte[i] = lane_byte[i-d];
                        end
                    end
                end
            end
        end
    end

    for (genvar k = 0; k < yay0lz_pkg::OUT_BYTES; k++) begin : g_out
        if (k < LANES) begin : g_used
            assign out_bytes[k*BYTE_W +: BYTE_W] =
                (CNT_W'(k) < chunk) ? lane_byte[k] : '0;
        end else begin : g_pad
            assign out_bytes[k*BYTE_W +: BYTE_W] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_wp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_res.ready && !fire) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_LOAD: begin
                    if (o_pop) begin
                        r_tok      <= i_pop_data;
                        r_len_left <= i_pop_data.len;
                        r_state    <= load_read ? ST_READ : ST_EMIT;
                    end
                end
                ST_READ: begin
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (fire) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= out_bytes;
                        r_out_count <= yay0lz_pkg::COUNT_W'(chunk);
                        r_out_last  <= last_group;
                        r_out_done  <= last_group && r_tok.done;
                        r_out_bad   <= r_tok.bad;
                        r_wp        <= r_wp + ADDR_W'(chunk);
                        if (last_group) begin
                            if (o_pop) begin
                                r_tok      <= i_pop_data;
                                r_len_left <= i_pop_data.len;
                                r_state    <= load_read ? ST_READ : ST_EMIT;
                            end else begin
                                r_state <= ST_LOAD;
                            end
                        end else begin
                            r_len_left <= r_len_left - LEN_W'(chunk);
                            r_state    <= (r_tok.is_copy && !r_tok.bad) ? ST_READ
                                                                        : ST_EMIT;
                        end
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.data_bytes  = r_out_data;
    assign o_res.byte_count  = r_out_count;
    assign o_res.last        = r_out_last;
    assign o_res.stream_done = r_out_done;
    assign o_res.bad_ref     = r_out_bad;

endmodule

// File: rtl/yay0_lz_decoder_unit.sv
// ----------------------------------------------------------------------------
// yay0_lz_decoder_unit
// Token-level Yay0 LZ decoder: literal and copy tokens in, groups of
// decoded bytes out, with a configurable decoded size.
// ----------------------------------------------------------------------------
// channel  dir  handshake        payload
// i_tok    in   valid / ready    req_type, literal_byte, link_word, extra_length
// o_res    out  valid / ready    data_bytes, byte_count, last, stream_done, bad_ref
// apb      in   psel / penable   paddr, pwdata, prdata; total_size at 0x0
//
// a literal goes straight to merge and emit; a copy takes a history bank read,
// then merge and emit, for each group of LANES bytes; any token also passes
// through the load state when the copy engine was waiting on an empty token queue.
// a reference before the start emits one group of zeros per cycle unless the result channel stalls.
// a four-entry token queue lets the front keep accepting while results stall.
// reset is synchronous, active low; history has no clearing pass and only
// written bytes are ever read back.
// ----------------------------------------------------------------------------
module yay0_lz_decoder_unit #(
    parameter int WINDOW_DEPTH = yay0lz_pkg::WINDOW_DEPTH_DEF,
    parameter int LANES        = yay0lz_pkg::LANES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    yay0lz_tok_if.sink  i_tok,
    yay0lz_res_if.source o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SIZE_W = yay0lz_pkg::SIZE_W;

    logic [SIZE_W-1:0]      r_total_size;
    logic                   reg_sel;
    yay0lz_pkg::t_cfg_wr    cfg_wr;
    logic                   push;
    yay0lz_pkg::t_token     push_data;
    logic                   pop;
    yay0lz_pkg::t_token     pop_data;
    yay0lz_pkg::t_q_status  q_status;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == yay0lz_pkg::REG_TOTAL_SIZE);

    assign cfg_wr.we         = psel && penable && pwrite && pready && reg_sel;
    assign cfg_wr.total_size = pwdata[SIZE_W-1:0];

    assign prdata = reg_sel ? 32'(r_total_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_size <= '0;
        end else if (cfg_wr.we) begin
            r_total_size <= cfg_wr.total_size;
        end
    end

    yay0lz_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok       (i_tok),
        .i_cfg       (cfg_wr),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_push_data (push_data)
    );

    yay0lz_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_status    (q_status)
    );

    yay0lz_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .LANES        (LANES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pop_data (pop_data),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_res      (o_res)
    );

    a_push_not_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_status.full)
        else $error("token pushed into a full queue");

    a_bad_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.bad_ref |-> o_res.data_bytes == '0)
        else $error("bad reference result carries data");

    a_count_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (LANES < 16) |-> o_res.byte_count != '0)
        else $error("result with no bytes");

    a_done_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.stream_done |-> o_res.last)
        else $error("stream done on a result that is not last");

endmodule
